@@ hdl/rsa_pkg.sv @@
// rsa_pkg: shared types and constants for the refcounted slot allocator
// used by rsa_slot_unit and refcounted_slot_allocator_top; no dependencies
package rsa_pkg;

  localparam int ADDR_W     = 24;
  localparam int COUNT_W    = 8;
  localparam int INUSE_W    = 4;
  localparam int SLOT_COUNT = 8;
  localparam int SLOT_BYTES = 262144;

  localparam int SLOT_IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  // unwrapped slot bounds: base plus the whole region
  localparam int LO_W = $clog2((1 << ADDR_W) + SLOT_COUNT * SLOT_BYTES + 1);

  localparam logic [COUNT_W-1:0] COUNT_MAX = 8'd255;
  localparam logic [INUSE_W-1:0] INUSE_MAX = 4'd15;

  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_ADDREF  = 2'd1,
    OP_RELEASE = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]        operation;
    logic [ADDR_W-1:0] request_bytes;
    logic [ADDR_W-1:0] slot_address;
    logic              address_is_none;
  } in_item_t;

  typedef struct packed {
    logic               granted;
    logic [ADDR_W-1:0]  granted_address;
    logic [INUSE_W-1:0] slots_in_use;
  } out_item_t;

  typedef struct packed {
    logic grant_en;
    logic inc_en;
    logic dec_en;
  } slot_ctl_t;

  typedef struct packed {
    logic               grant;
    logic [COUNT_W-1:0] new_count;
  } slot_res_t;

endpackage

@@ hdl/rsa_slot_unit.sv @@
// rsa_slot_unit: shared per-slot compare and count update, one slot per cycle
// depends on rsa_pkg
module rsa_slot_unit
  import rsa_pkg::*;
(
  input  slot_ctl_t          ctl,
  input  logic [ADDR_W-1:0]  addr,
  input  logic [LO_W-1:0]    slot_lo,
  input  logic [LO_W-1:0]    slot_hi,
  input  logic [COUNT_W-1:0] count,
  output slot_res_t          res
);

  logic [LO_W-1:0] addr_ext;
  logic            hit;

  assign addr_ext = LO_W'(addr);
  assign hit      = (addr_ext >= slot_lo) && (addr_ext < slot_hi);

  always_comb begin
    res.grant     = 1'b0;
    res.new_count = count;
    if (ctl.grant_en && (count == '0)) begin
      res.grant     = 1'b1;
      res.new_count = COUNT_W'(1);
    end else if (ctl.inc_en && hit && (count != COUNT_MAX)) begin
      res.new_count = count + COUNT_W'(1);
    end else if (ctl.dec_en && hit && (count != '0)) begin
      res.new_count = count - COUNT_W'(1);
    end
  end

endmodule

@@ hdl/refcounted_slot_allocator_top.sv @@
// refcounted_slot_allocator_top: sequencer, refcount store and result register
// depends on rsa_pkg and rsa_slot_unit
//
// usage:
// - input channel in_valid/in_stall/in_data carries one request per transfer;
//   operation selects allocate, add reference or release
// - result channel out_valid/out_stall/out_data returns exactly one result
//   per request: grant flag, granted base address and slots in use
// - cfg_wr_en/cfg_wr_data write the slot region base; write only when idle
// - each request walks all slots through one shared compare/update unit,
//   one slot per cycle; the result is written to the output register after
//   the walk, and a new request is taken only once the walk has finished
//   and its result has entered the output register
// - in_stall is high while a request is being walked or waits in ST_DONE;
//   a new request is taken while an earlier result still waits in the output register
// - if out_stall holds the previous result, the finished walk waits in its
//   last state until the output register frees
// - reset clears all reference counts, the region base and out_valid
module refcounted_slot_allocator_top
  import rsa_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [ADDR_W-1:0] cfg_wr_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_item_t          in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output out_item_t         out_data
);

  state_t                 state_r, state_nxt;
  logic [ADDR_W-1:0]      base_r;
  logic [COUNT_W-1:0]     refcnt_r [SLOT_COUNT];
  logic [SLOT_IDX_W-1:0]  idx_r;
  logic [LO_W-1:0]        slot_lo_r;
  logic [LO_W-1:0]        slot_hi_r;
  slot_ctl_t              ctl_r;
  logic [ADDR_W-1:0]      addr_r;
  logic                   granted_r;
  logic [ADDR_W-1:0]      gaddr_r;
  logic [INUSE_W-1:0]     inuse_r;
  logic                   out_valid_r;
  out_item_t              out_item_r;

  logic                   accept;
  logic                   last_slot;
  logic                   out_free;
  slot_ctl_t              ctl_in;
  slot_ctl_t              ctl_cur;
  slot_res_t              res;

  assign accept    = in_valid && !in_stall;
  assign last_slot = (idx_r == SLOT_IDX_W'(SLOT_COUNT - 1));
  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

  // decode the request once at transfer
  always_comb begin
    ctl_in.grant_en = (in_data.operation == OP_ALLOC) &&
                      (in_data.request_bytes <= ADDR_W'(SLOT_BYTES));
    ctl_in.inc_en   = (in_data.operation == OP_ADDREF) && !in_data.address_is_none;
    ctl_in.dec_en   = (in_data.operation == OP_RELEASE) && !in_data.address_is_none;
  end

  // grant stays enabled only until the lowest free slot is taken
  always_comb begin
    ctl_cur          = ctl_r;
    ctl_cur.grant_en = ctl_r.grant_en && !granted_r;
  end

  rsa_slot_unit u_slot_unit (
    .ctl     (ctl_cur),
    .addr    (addr_r),
    .slot_lo (slot_lo_r),
    .slot_hi (slot_hi_r),
    .count   (refcnt_r[idx_r]),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (last_slot) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= '0;
    end else if (cfg_wr_en) begin
      base_r <= cfg_wr_data;
    end
  end

  // reference count store
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOT_COUNT; i++) refcnt_r[i] <= '0;
    end else if (state_r == ST_SCAN) begin
      refcnt_r[idx_r] <= res.new_count;
    end
  end

  // walk state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r     <= '0;
      granted_r <= 1'b0;
    end else if (accept) begin
      ctl_r     <= ctl_in;
      granted_r <= 1'b0;
    end else if ((state_r == ST_SCAN) && res.grant) begin
      granted_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      addr_r    <= in_data.slot_address;
      idx_r     <= '0;
      slot_lo_r <= LO_W'(base_r);
      slot_hi_r <= LO_W'(base_r) + LO_W'(SLOT_BYTES);
      gaddr_r   <= '0;
      inuse_r   <= '0;
    end else if (state_r == ST_SCAN) begin
      idx_r     <= idx_r + SLOT_IDX_W'(1);
      slot_lo_r <= slot_hi_r;
      slot_hi_r <= slot_hi_r + LO_W'(SLOT_BYTES);
      if (res.grant) gaddr_r <= slot_lo_r[ADDR_W-1:0];
      if ((res.new_count != '0) && (inuse_r != INUSE_MAX)) begin
        inuse_r <= inuse_r + INUSE_W'(1);
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == ST_DONE) && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == ST_DONE) && out_free) begin
      out_item_r.granted         <= granted_r;
      out_item_r.granted_address <= gaddr_r;
      out_item_r.slots_in_use    <= inuse_r;
    end
  end

  a_accept_starts_walk: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == ST_SCAN) && (idx_r == '0))
    else $error("transfer did not start a slot walk");

  a_one_op: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({ctl_r.grant_en, ctl_r.inc_en, ctl_r.dec_en}))
    else $error("more than one operation enabled");

  a_no_grant_no_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_item_r.granted) |-> (out_item_r.granted_address == '0))
    else $error("address reported without a grant");

  a_grant_only_alloc: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_SCAN) && res.grant) |-> (ctl_r.grant_en && !granted_r))
    else $error("grant outside an allocate walk");

  a_inuse_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (32'(out_item_r.slots_in_use) <= 32'(SLOT_COUNT)))
    else $error("slots in use exceeds slot count");

endmodule
